/* hw/rtl/imucal_pkg.sv */
// ----------------------------------------------------------------------------
// imucal_pkg
// Shared widths, codes, state type and the saturation helper for the IMU
// scale and offset calibration unit.
// ----------------------------------------------------------------------------
package imucal_pkg;

   // Field widths
   localparam int RAW_W     = 16;   // raw sensor sample
   localparam int OUT_W     = 29;   // scaled / calibrated output
   localparam int SUM_W     = 45;   // calibration accumulator
   localparam int CNT_W     = 16;   // sample counter
   localparam int NUM_AXES  = 6;    // accel x/y/z then gyro x/y/z
   localparam int AXIS_W    = 3;    // index into the six axes

   // Coefficients carry this many extra fraction bits
   localparam int COEF_FRAC = 16;

   // Default output fraction bits
   localparam int FRAC_BITS_DEF = 16;

   // Axis positions
   localparam logic [AXIS_W-1:0] AXIS_AZ   = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_LAST = 3'(NUM_AXES - 1);

   // Operation codes
   typedef enum logic {
      OP_MEASURE = 1'b0,
      OP_CALIB   = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ACCEL_RANGE   = 2'd0,
      CSR_GYRO_RANGE    = 2'd1,
      CSR_CALIB_SAMPLES = 2'd2
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MERGE,
      ST_DIV_START,
      ST_DIV_WAIT
   } state_type;

   // Lane strobes
   typedef struct packed {
      logic load_prod;
      logic load_scaled;
   } lane_ctl_type;

   // Saturate a value one bit wider than the output to the output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[OUT_W] != v[OUT_W-1]) begin
         r = v[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/imucal_lane.sv */
// ----------------------------------------------------------------------------
// imucal_lane
// One scaling lane: raw * coefficient, round half up, drop the coefficient
// fraction bits and saturate to the output range. Two register stages.
// ----------------------------------------------------------------------------
module imucal_lane
   import imucal_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  lane_ctl_type                ctl,
   input  logic signed [RAW_W-1:0]     raw,
   input  logic [FRAC_BITS+12:0]       coef,
   output logic signed [OUT_W-1:0]     scaled
);

   localparam int COEF_W = FRAC_BITS + 13;
   localparam int PROD_W = RAW_W + COEF_W + 1;
   localparam int SH_W   = PROD_W + 1 - COEF_FRAC;
   localparam int EXT_W  = (SH_W > OUT_W) ? SH_W : OUT_W;
   localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'(2 ** (OUT_W - 1) - 1);
   localparam logic signed [EXT_W-1:0] LIM_LO = -LIM_HI - EXT_W'(1);

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W:0]   rnd;
   logic signed [SH_W-1:0]   shifted;
   logic signed [EXT_W-1:0]  shifted_ext;
   logic signed [OUT_W-1:0]  scaled_in;
   logic signed [OUT_W-1:0]  scaled_ff;

   // Stage 1: multiply
   assign prod_in = raw * $signed({1'b0, coef});

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: round, shift, saturate
   assign rnd         = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(1 << (COEF_FRAC - 1));
   assign shifted     = $signed(rnd[PROD_W:COEF_FRAC]);
   assign shifted_ext = EXT_W'(shifted);

   always_comb begin
      if (shifted_ext > LIM_HI) begin
         scaled_in = OUT_W'(LIM_HI);
      end else if (shifted_ext < LIM_LO) begin
         scaled_in = OUT_W'(LIM_LO);
      end else begin
         scaled_in = OUT_W'(shifted_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_scaled) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

/* hw/rtl/imucal_div.sv */
// ----------------------------------------------------------------------------
// imucal_div
// Shared restoring divider: signed sum over unsigned count, quotient
// truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module imucal_div
   import imucal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [CNT_W:0]           divisor,
   output logic                     done,
   output logic signed [OUT_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [CNT_W:0]      rem_ff;
   logic [CNT_W:0]      rem_in;
   logic [SUM_W-1:0]    quo_ff;
   logic [SUM_W-1:0]    quo_in;
   logic [CNT_W:0]      divisor_ff;
   logic                neg_ff;
   logic [SUM_W-1:0]    mag;
   logic [CNT_W+1:0]    rem_shift;
   logic                fits;
   logic [OUT_W-1:0]    quo_mag;

   // Magnitude of the dividend
   assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

   // One restoring step
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_in    = fits ? (CNT_W+1)'(rem_shift - {1'b0, divisor_ff})
                           : rem_shift[CNT_W:0];
   assign quo_in    = {quo_ff[SUM_W-2:0], fits};

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= mag;
         divisor_ff <= divisor;
         neg_ff     <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Mean magnitude fits the output width
   assign quo_mag  = quo_ff[OUT_W-1:0];
   assign quotient = $signed(neg_ff ? OUT_W'(-quo_mag) : quo_mag);
   assign done     = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

/* hw/rtl/imu_scale_and_offset_calibration_unit.sv */
// Each accepted transaction passes the lane product register, the lane scaled
// register and the output register; the merge waits for a free output, and the next
// transaction is taken only after it. Closing a calibration run adds the shared
// one-bit-per-cycle divider, axis by axis, before the next transaction is taken.
// Reset: ranges go to 16 g / 2000 dps, sample count 1, offsets invalid, no run.
// ----------------------------------------------------------------------------
// imu_scale_and_offset_calibration_unit
// Six scaling lanes feed a merge stage that applies offsets or accumulates a
// calibration run; the run's means come from a shared sequential divider.
// ----------------------------------------------------------------------------
module imu_scale_and_offset_calibration_unit
   import imucal_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CNT_W-1:0]         csr_data,
   // Input samples
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [RAW_W-1:0]  req_accel_x,
   input  logic signed [RAW_W-1:0]  req_accel_y,
   input  logic signed [RAW_W-1:0]  req_accel_z,
   input  logic signed [RAW_W-1:0]  req_gyro_x,
   input  logic signed [RAW_W-1:0]  req_gyro_y,
   input  logic signed [RAW_W-1:0]  req_gyro_z,
   // Results
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_out_accel_x,
   output logic signed [OUT_W-1:0]  rsp_out_accel_y,
   output logic signed [OUT_W-1:0]  rsp_out_accel_z,
   output logic signed [OUT_W-1:0]  rsp_out_gyro_x,
   output logic signed [OUT_W-1:0]  rsp_out_gyro_y,
   output logic signed [OUT_W-1:0]  rsp_out_gyro_z,
   output logic                     rsp_calibrated,
   output logic                     rsp_calibration_done
);

   localparam int COEF_W = FRAC_BITS + 13;

   // Gyro reciprocals, round half up, with COEF_FRAC extra fraction bits
   localparam logic [COEF_W-1:0] GYRO_COEF_250 =
      COEF_W'(((64'd1 << (FRAC_BITS + 17)) + 64'd131) / 64'd262);
   localparam logic [COEF_W-1:0] GYRO_COEF_500 =
      COEF_W'(((64'd2 << (FRAC_BITS + 17)) + 64'd131) / 64'd262);
   localparam logic [COEF_W-1:0] GYRO_COEF_1000 =
      COEF_W'(((64'd5 << (FRAC_BITS + 17)) + 64'd164) / 64'd328);
   localparam logic [COEF_W-1:0] GYRO_COEF_2000 =
      COEF_W'(((64'd5 << (FRAC_BITS + 17)) + 64'd82) / 64'd164);

   localparam logic signed [OUT_W:0] ONE_G = (OUT_W+1)'(2 ** FRAC_BITS);

   // Configuration registers
   logic [1:0]               accel_range_ff;
   logic [1:0]               gyro_range_ff;
   logic [CNT_W-1:0]         calib_samples_ff;

   // Sequencer
   state_type                state_ff;
   state_type                state_in;
   lane_ctl_type             lane_ctl;
   logic                     merge_fire;
   logic                     div_start;
   logic                     offset_wr;
   logic                     out_free;

   // Calibration state
   op_type                   op_ff;
   logic signed [SUM_W-1:0]  sum_ff [NUM_AXES];
   logic signed [SUM_W-1:0]  sum_in [NUM_AXES];
   logic signed [OUT_W-1:0]  offset_ff [NUM_AXES];
   logic [CNT_W-1:0]         sample_count_ff;
   logic                     offsets_valid_ff;
   logic [AXIS_W-1:0]        div_idx_ff;
   logic [CNT_W:0]           div_n_ff;

   // Merge terms
   logic [CNT_W-1:0]         cnt_inc;
   logic [CNT_W-1:0]         target;
   logic                     run_end;
   logic signed [OUT_W-1:0]  result_in [NUM_AXES];
   logic signed [OUT_W-1:0]  div_q;
   logic                     div_done;
   logic signed [OUT_W:0]    z_adj;
   logic signed [OUT_W-1:0]  offset_in;

   // Lanes
   logic [COEF_W-1:0]        accel_coef;
   logic [COEF_W-1:0]        gyro_coef;
   logic signed [RAW_W-1:0]  raw [NUM_AXES];
   logic signed [OUT_W-1:0]  scaled [NUM_AXES];

   // Output register
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_axis_ff [NUM_AXES];
   logic                     rsp_calibrated_ff;
   logic                     rsp_done_ff;

   // Configuration writes, taken whenever offered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_range_ff   <= 2'd3;
         gyro_range_ff    <= 2'd3;
         calib_samples_ff <= CNT_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL_RANGE:   accel_range_ff   <= csr_data[1:0];
            CSR_GYRO_RANGE:    gyro_range_ff    <= csr_data[1:0];
            CSR_CALIB_SAMPLES: calib_samples_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Coefficient selection
   assign accel_coef = COEF_W'(1) << (FRAC_BITS + 2 + 32'(accel_range_ff));

   always_comb begin
      case (gyro_range_ff)
         2'd0:    gyro_coef = GYRO_COEF_250;
         2'd1:    gyro_coef = GYRO_COEF_500;
         2'd2:    gyro_coef = GYRO_COEF_1000;
         default: gyro_coef = GYRO_COEF_2000;
      endcase
   end

   assign raw[0] = req_accel_x;
   assign raw[1] = req_accel_y;
   assign raw[2] = req_accel_z;
   assign raw[3] = req_gyro_x;
   assign raw[4] = req_gyro_y;
   assign raw[5] = req_gyro_z;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      imucal_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .raw    (raw[i]),
         .coef   ((i < 3) ? accel_coef : gyro_coef),
         .scaled (scaled[i])
      );
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and strobes
   always_comb begin
      state_in             = state_ff;
      lane_ctl.load_prod   = 1'b0;
      lane_ctl.load_scaled = 1'b0;
      merge_fire           = 1'b0;
      div_start            = 1'b0;
      offset_wr            = 1'b0;
      req_ready            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               lane_ctl.load_prod = 1'b1;
               state_in           = ST_SCALE;
            end
         end
         ST_SCALE: begin
            lane_ctl.load_scaled = 1'b1;
            state_in             = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               merge_fire = 1'b1;
               state_in   = (op_ff == OP_CALIB && run_end) ? ST_DIV_START : ST_IDLE;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               offset_wr = 1'b1;
               state_in  = (div_idx_ff == AXIS_LAST) ? ST_IDLE : ST_DIV_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff <= op_type'(req_operation);
      end
   end

   // Run bookkeeping
   assign cnt_inc = sample_count_ff + CNT_W'(1);
   assign target  = (calib_samples_ff == '0) ? CNT_W'(1) : calib_samples_ff;
   assign run_end = (cnt_inc == '0) || (cnt_inc >= target);

   // Merge: accumulate or subtract offsets
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sum_in[i] = ((sample_count_ff == '0) ? '0 : sum_ff[i]) + SUM_W'(scaled[i]);
         if (op_ff == OP_MEASURE && offsets_valid_ff) begin
            result_in[i] = sat_out((OUT_W+1)'(scaled[i]) - (OUT_W+1)'(offset_ff[i]));
         end else begin
            result_in[i] = scaled[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= '0;
         offsets_valid_ff <= 1'b0;
         div_idx_ff       <= '0;
      end else begin
         if (merge_fire && op_ff == OP_CALIB) begin
            sample_count_ff <= run_end ? '0 : cnt_inc;
            div_idx_ff      <= '0;
            if (sample_count_ff == '0) begin
               offsets_valid_ff <= 1'b0;
            end
         end
         if (offset_wr) begin
            div_idx_ff <= div_idx_ff + AXIS_W'(1);
            if (div_idx_ff == AXIS_LAST) begin
               offsets_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Sums and divisor, meaningful only inside a run
   always_ff @(posedge clock) begin
      if (merge_fire && op_ff == OP_CALIB) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         div_n_ff <= {cnt_inc == '0, cnt_inc};
      end
   end

   // Means, one axis at a time
   imucal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[div_idx_ff]),
      .divisor  (div_n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Accel Z mean has 1 g removed with the sign of the mean
   assign z_adj     = div_q[OUT_W-1] ? (OUT_W+1)'(div_q) + ONE_G
                                     : (OUT_W+1)'(div_q) - ONE_G;
   assign offset_in = (div_idx_ff == AXIS_AZ) ? sat_out(z_adj) : div_q;

   // Offsets are read only while valid
   always_ff @(posedge clock) begin
      if (offset_wr) begin
         offset_ff[div_idx_ff] <= offset_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (merge_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_fire) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            rsp_axis_ff[i] <= result_in[i];
         end
         rsp_calibrated_ff <= (op_ff == OP_MEASURE) && offsets_valid_ff;
         rsp_done_ff       <= (op_ff == OP_CALIB) && run_end;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_accel_x      = rsp_axis_ff[0];
   assign rsp_out_accel_y      = rsp_axis_ff[1];
   assign rsp_out_accel_z      = rsp_axis_ff[2];
   assign rsp_out_gyro_x       = rsp_axis_ff[3];
   assign rsp_out_gyro_y       = rsp_axis_ff[4];
   assign rsp_out_gyro_z       = rsp_axis_ff[5];
   assign rsp_calibrated       = rsp_calibrated_ff;
   assign rsp_calibration_done = rsp_done_ff;

   a_cal_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_calibrated_ff && rsp_done_ff))
      else $error("result both offset-corrected and closing a run");

   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_START || state_ff == ST_DIV_WAIT)
         |-> (sample_count_ff == '0 && !offsets_valid_ff))
      else $error("divide phase with open count or valid offsets");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(offsets_valid_ff)
         |-> $past(state_ff == ST_DIV_WAIT && div_done && div_idx_ff == AXIS_LAST))
      else $error("offsets marked valid outside the last mean write");

endmodule

/* sim/imucal_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU calibration unit checker
// Watches the register, sample and result channels of the IMU scale and
// offset calibration unit. Keeps its own copy of the ranges, the calibration
// run and the stored offsets, predicts every result, and compares results in
// order, field by field.
// ----------------------------------------------------------------------------
module imucal_checker
   import imucal_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CNT_W-1:0]         csr_data,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [RAW_W-1:0]  req_accel_x,
   input  logic signed [RAW_W-1:0]  req_accel_y,
   input  logic signed [RAW_W-1:0]  req_accel_z,
   input  logic signed [RAW_W-1:0]  req_gyro_x,
   input  logic signed [RAW_W-1:0]  req_gyro_y,
   input  logic signed [RAW_W-1:0]  req_gyro_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [OUT_W-1:0]  rsp_out_accel_x,
   input  logic signed [OUT_W-1:0]  rsp_out_accel_y,
   input  logic signed [OUT_W-1:0]  rsp_out_accel_z,
   input  logic signed [OUT_W-1:0]  rsp_out_gyro_x,
   input  logic signed [OUT_W-1:0]  rsp_out_gyro_y,
   input  logic signed [OUT_W-1:0]  rsp_out_gyro_z,
   input  logic                     rsp_calibrated,
   input  logic                     rsp_calibration_done,
   output int                       errors,
   output int                       pending
);

   localparam int     MAX_REPORTS = 200;
   localparam longint UNITS_HI    = (64'sd1 <<< (OUT_W - 1)) - 1;
   localparam longint UNITS_LO    = -(64'sd1 <<< (OUT_W - 1));

   typedef logic signed [RAW_W-1:0] raw_type;
   typedef logic signed [OUT_W-1:0] units_type;

   typedef struct packed {
      units_type ax;
      units_type ay;
      units_type az;
      units_type gx;
      units_type gy;
      units_type gz;
      logic      calibrated;
      logic      done;
   } sample_out_type;

   // Shadow of the block: ranges, run progress, sums and offsets
   // (axes 0..2 accel, 3..5 gyro)
   logic [1:0]       accel_fs;
   logic [1:0]       gyro_fs;
   logic [CNT_W-1:0] run_length;
   logic [CNT_W-1:0] run_count;
   logic             bias_valid;
   longint           total [NUM_AXES];
   longint           bias  [NUM_AXES];

   sample_out_type expected_samples [$];
   int             fail_tally = 0;
   int             results_seen = 0;

   assign errors = fail_tally;

   // Clamp to the signed output range
   function automatic units_type to_units(input longint v);
      if (v > UNITS_HI) begin
         return units_type'(UNITS_HI);
      end
      if (v < UNITS_LO) begin
         return units_type'(UNITS_LO);
      end
      return units_type'(v);
   endfunction

   // Reciprocal of the gyro sensitivity, rounded half up, with COEF_FRAC extra bits
   function automatic longint gyro_coef(input logic [1:0] fs);
      longint num;
      longint den;
      case (fs)
         2'd0: begin
            num = 131; den = 1;
         end
         2'd1: begin
            num = 131; den = 2;
         end
         2'd2: begin
            num = 164; den = 5;
         end
         default: begin
            num = 82;  den = 5;
         end
      endcase
      return ((den <<< (FRAC_BITS + COEF_FRAC + 1)) + num) / (2 * num);
   endfunction

   // Scale one sample, then either accumulate it into the run or remove offsets
   function automatic sample_out_type predict_sample(input op_type op,
                                                     input raw_type raw [NUM_AXES]);
      units_type      scaled [NUM_AXES];
      units_type      res    [NUM_AXES];
      longint         coef;
      longint         n;
      longint         one_g;
      int             target;
      sample_out_type r;
      r.calibrated = 1'b0;
      r.done       = 1'b0;
      one_g        = 64'sd1 <<< FRAC_BITS;
      for (int k = 0; k < NUM_AXES; k++) begin
         coef = (k < 3) ? (64'sd1 <<< (FRAC_BITS + 2 + int'(accel_fs))) : gyro_coef(gyro_fs);
         scaled[k] = to_units((longint'(raw[k]) * coef + (64'sd1 <<< (COEF_FRAC - 1)))
                              >>> COEF_FRAC);
         res[k] = scaled[k];
      end
      if (op == OP_CALIB) begin
         target = (run_length == 0) ? 1 : int'(run_length);
         // first sample of a run clears the sums and drops the old offsets
         if (run_count == 0) begin
            foreach (total[k]) total[k] = 0;
            bias_valid = 1'b0;
         end
         foreach (total[k]) total[k] += longint'(scaled[k]);
         run_count = run_count + 1'b1;
         if (run_count == 0 || int'(run_count) >= target) begin
            n = (run_count == 0) ? 64'sd65536 : longint'(run_count);
            foreach (bias[k]) bias[k] = total[k] / n;
            // gravity sits on Z: remove 1 g with the sign of the mean
            bias[AXIS_AZ] = to_units((bias[AXIS_AZ] >= 0) ? bias[AXIS_AZ] - one_g
                                                          : bias[AXIS_AZ] + one_g);
            bias_valid = 1'b1;
            run_count  = '0;
            r.done     = 1'b1;
         end
      end else begin
         r.calibrated = bias_valid;
         if (bias_valid) begin
            foreach (res[k]) res[k] = to_units(longint'(scaled[k]) - bias[k]);
         end
      end
      r.ax = res[0];
      r.ay = res[1];
      r.az = res[2];
      r.gx = res[3];
      r.gy = res[4];
      r.gz = res[5];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fail_tally++;
      if (fail_tally <= MAX_REPORTS) begin
         $display("%0t ns: mismatch %0d on result %0d: %s", $time, fail_tally, results_seen,
                  what);
      end
   endtask

   task automatic check_field(input string name, input units_type got, input units_type want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // Channel monitor: registers, then results, then new samples
   always @(posedge clock) begin : monitor
      raw_type        raw [NUM_AXES];
      sample_out_type want;
      if (reset) begin
         accel_fs   = 2'd3;
         gyro_fs    = 2'd3;
         run_length = CNT_W'(1);
         run_count  = '0;
         bias_valid = 1'b0;
         foreach (total[k]) begin
            total[k] = 0;
            bias[k]  = 0;
         end
         expected_samples.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_RANGE:   accel_fs   = csr_data[1:0];
               CSR_GYRO_RANGE:    gyro_fs    = csr_data[1:0];
               CSR_CALIB_SAMPLES: run_length = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_samples.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = expected_samples.pop_front();
               check_field("out_accel_x", rsp_out_accel_x, want.ax);
               check_field("out_accel_y", rsp_out_accel_y, want.ay);
               check_field("out_accel_z", rsp_out_accel_z, want.az);
               check_field("out_gyro_x", rsp_out_gyro_x, want.gx);
               check_field("out_gyro_y", rsp_out_gyro_y, want.gy);
               check_field("out_gyro_z", rsp_out_gyro_z, want.gz);
               check_field("calibrated", units_type'(rsp_calibrated),
                           units_type'(want.calibrated));
               check_field("calibration_done", units_type'(rsp_calibration_done),
                           units_type'(want.done));
            end
         end
         if (req_valid && req_ready) begin
            raw[0] = req_accel_x;
            raw[1] = req_accel_y;
            raw[2] = req_accel_z;
            raw[3] = req_gyro_x;
            raw[4] = req_gyro_y;
            raw[5] = req_gyro_z;
            expected_samples.push_back(predict_sample(op_type'(req_operation), raw));
         end
         pending <= expected_samples.size();
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU scale and offset calibration unit testbench
// Drives directed corner samples and then random calibration runs with
// measurements around them, under changing ranges and run lengths, with
// random idling on both channels, one long result stall and one quiet
// stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
   import imucal_pkg::*;
();

   localparam int IDLE_PCT       = 8;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 6 * 47 + 20;   // covers the divider after a run
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET    = 1900;

   typedef logic signed [RAW_W-1:0] raw_type;

   localparam raw_type R_MAX = 16'sh7FFF;
   localparam raw_type R_MIN = 16'sh8000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index = CSR_ACCEL_RANGE;
   logic [CNT_W-1:0]        csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_operation = OP_MEASURE;
   logic signed [RAW_W-1:0] req_accel_x = '0;
   logic signed [RAW_W-1:0] req_accel_y = '0;
   logic signed [RAW_W-1:0] req_accel_z = '0;
   logic signed [RAW_W-1:0] req_gyro_x = '0;
   logic signed [RAW_W-1:0] req_gyro_y = '0;
   logic signed [RAW_W-1:0] req_gyro_z = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out_accel_x;
   logic signed [OUT_W-1:0] rsp_out_accel_y;
   logic signed [OUT_W-1:0] rsp_out_accel_z;
   logic signed [OUT_W-1:0] rsp_out_gyro_x;
   logic signed [OUT_W-1:0] rsp_out_gyro_y;
   logic signed [OUT_W-1:0] rsp_out_gyro_z;
   logic                    rsp_calibrated;
   logic                    rsp_calibration_done;
   int                      errors;
   int                      pending;

   // Stimulus bookkeeping
   logic    quiet = 1'b0;           // no idling on either side while set
   int      rx_hold_seq = 0;        // bump to ask the receiver for a long stall
   int      rx_hold_seen = 0;
   int      rx_hold_left = 0;
   int      stall_cycles = 0;
   int      n_sent = 0;
   int      n_measure = 0;
   int      n_calib = 0;
   int      n_settings = 0;
   raw_type run_center [NUM_AXES];
   int      run_spread = 0;

   imu_scale_and_offset_calibration_unit dut (.*);

   imucal_checker sample_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random back-pressure, or a long hold when asked
   always @(posedge clock) begin
      if (rx_hold_seq != rx_hold_seen) begin
         rx_hold_seen <= rx_hold_seq;
         rx_hold_left <= RX_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", stall_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic raw_type pick_raw();
      case ($urandom_range(7))
         0:       return R_MAX;
         1:       return R_MIN;
         2:       return raw_type'(int'($urandom_range(8)) - 4);
         default: return raw_type'($urandom);
      endcase
   endfunction

   function automatic raw_type jitter(input raw_type c, input int spread);
      int v;
      v = int'(c) + int'($urandom_range(2 * spread)) - spread;
      if (v > int'(R_MAX)) begin
         v = int'(R_MAX);
      end else if (v < int'(R_MIN)) begin
         v = int'(R_MIN);
      end
      return raw_type'(v);
   endfunction

   // Offer one sample and hold it until accepted; maybe idle afterwards
   task automatic send_sample(input op_type op, input raw_type ax, input raw_type ay,
                              input raw_type az, input raw_type gx, input raw_type gy,
                              input raw_type gz);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_accel_x   <= ax;
      req_accel_y   <= ay;
      req_accel_z   <= az;
      req_gyro_x    <= gx;
      req_gyro_y    <= gy;
      req_gyro_z    <= gz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      if (op == OP_CALIB) begin
         n_calib++;
      end else begin
         n_measure++;
      end
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   // One sample scattered around the current run's center
   task automatic send_near(input op_type op);
      send_sample(op, jitter(run_center[0], run_spread), jitter(run_center[1], run_spread),
                  jitter(run_center[2], run_spread), jitter(run_center[3], run_spread),
                  jitter(run_center[4], run_spread), jitter(run_center[5], run_spread));
   endtask

   // Stop offering, wait for every result, then let the divider finish
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write all three registers; range writes carry junk in the unused bits
   task automatic program_ranges(input logic [1:0] a_fs, input logic [1:0] g_fs,
                                 input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] junk;
      junk = CNT_W'($urandom);
      put_reg(CSR_ACCEL_RANGE, {junk[CNT_W-1:2], a_fs});
      junk = CNT_W'($urandom);
      put_reg(CSR_GYRO_RANGE, {junk[CNT_W-1:2], g_fs});
      put_reg(CSR_CALIB_SAMPLES, count);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin : stimulus
      int               phase;
      int               runs;
      int               len;
      logic [CNT_W-1:0] count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and rounding at reset ranges, single-sample run
      send_sample(OP_MEASURE, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX);
      send_sample(OP_MEASURE, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN);
      send_sample(OP_MEASURE, 0, 0, 0, 0, 0, 0);
      send_sample(OP_MEASURE, -1, -1, -1, -1, -1, -1);
      send_sample(OP_MEASURE, 1, -1, 1, -1, 1, -1);
      send_sample(OP_CALIB, 100, -100, 2048, 7, -7, 300);
      send_sample(OP_MEASURE, 100, -100, 2048, 7, -7, 300);
      send_sample(OP_MEASURE, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX);

      // Smallest ranges, zero run length acts as one; Z mean negative then zero
      drain_results();
      program_ranges(2'd0, 2'd0, '0);
      send_sample(OP_CALIB, 0, 0, -16384, 0, 0, 0);
      send_sample(OP_MEASURE, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN);
      send_sample(OP_CALIB, 0, 0, 0, 0, 0, 0);
      send_sample(OP_MEASURE, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX);

      // Longest run length: open a run, measure inside it
      drain_results();
      program_ranges(2'd3, 2'd3, '1);
      send_sample(OP_CALIB, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX);
      send_sample(OP_CALIB, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN);
      send_sample(OP_CALIB, 1234, -1234, 2048, -99, 99, 0);
      send_sample(OP_MEASURE, 5, 5, 5, 5, 5, 5);

      // Length lowered below progress and ranges changed inside the open run
      drain_results();
      program_ranges(2'd1, 2'd2, 16'd2);
      send_sample(OP_CALIB, 300, -300, 8192, 40, -40, 0);
      send_sample(OP_MEASURE, 300, -300, 8192, 40, -40, 0);
      drain_results();
      program_ranges(2'd2, 2'd1, 16'd1);
      send_sample(OP_MEASURE, R_MAX, R_MIN, R_MAX, R_MIN, R_MAX, R_MIN);
      send_sample(OP_MEASURE, R_MIN, R_MAX, R_MIN, R_MAX, R_MIN, R_MAX);

      // Random phases: calibration runs with measurements around them
      for (phase = 0; n_sent < ITEM_TARGET; phase++) begin
         drain_results();
         quiet <= (phase >= 6 && phase < 10);
         case ($urandom_range(19))
            0, 1:          count = '0;
            2, 3, 4, 5, 6: count = 16'd1;
            18, 19:        count = CNT_W'($urandom_range(40, 9));
            default:       count = CNT_W'($urandom_range(8, 2));
         endcase
         program_ranges(2'($urandom_range(3)), 2'($urandom_range(3)), count);

         // long result stall while samples keep coming
         if (phase == 3) begin
            rx_hold_seq <= rx_hold_seq + 1;
            for (int k = 0; k < NUM_AXES; k++) run_center[k] = pick_raw();
            run_spread = 256;
            repeat (12) send_near(OP_MEASURE);
         end

         if ($urandom_range(9) == 0) begin
            // noise: any operation, any values
            repeat (20) begin
               send_sample(op_type'($urandom_range(1)), pick_raw(), pick_raw(), pick_raw(),
                           pick_raw(), pick_raw(), pick_raw());
            end
         end else begin
            runs = $urandom_range(3, 1);
            repeat (runs) begin
               for (int k = 0; k < NUM_AXES; k++) begin
                  run_center[k] = $urandom_range(1) ? pick_raw()
                                                    : raw_type'(int'($urandom_range(4096)) - 2048);
               end
               run_spread = 1 << $urandom_range(10);
               len = (count == 0) ? 1 : int'(count);
               // sometimes leave the run unfinished for the next setting
               if ($urandom_range(6) == 0) begin
                  len = $urandom_range(len);
               end
               repeat (len) begin
                  if ($urandom_range(3) == 0) begin
                     send_near(OP_MEASURE);
                  end
                  send_near(OP_CALIB);
               end
               repeat ($urandom_range(6, 2)) send_near(OP_MEASURE);
            end
         end
      end

      drain_results();
      $display("Covered %0d measure and %0d calibration samples over %0d register settings,",
               n_measure, n_calib, n_settings);
      $display("with one long result stall and a stretch without idling; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
